// ===== rtl/tbu_pkg.sv =====
// ----------------------------------------------------------------------------
// tbu_pkg
// Shared types and constants of the ternary block unpacker.
// ----------------------------------------------------------------------------
package tbu_pkg;

    // Block geometry.
    localparam int unsigned CodesPerBlock = 256;
    localparam int unsigned PosWidth      = 7;

    // 2-bit format: 64 payload bytes, then the two scale bytes.
    localparam logic [PosWidth-1:0] Tq2Payload = PosWidth'(CodesPerBlock / 4);
    // Base-3 format: 48 five-trit bytes, 4 four-trit bytes, then the scale.
    localparam int unsigned Tq1Qh     = CodesPerBlock / 64;
    localparam int unsigned Tq1Qs     = (CodesPerBlock - 4 * Tq1Qh) / 5;
    localparam int unsigned Tq1QsFull = Tq1Qs - Tq1Qs % 32;
    localparam logic [PosWidth-1:0] Tq1Payload = PosWidth'(Tq1Qs + Tq1Qh);

    // Format register codes.
    localparam logic FMT_TQ2 = 1'b0;
    localparam logic FMT_TQ1 = 1'b1;

    // One decoded result.
    typedef struct packed {
        logic        [7:0]  base_position;
        logic        [5:0]  position_stride;
        logic        [2:0]  code_count;
        logic signed [2:0]  code0;
        logic signed [2:0]  code1;
        logic signed [2:0]  code2;
        logic signed [2:0]  code3;
        logic signed [1:0]  code4;
        logic               scale_valid;
        logic        [31:0] scale_bits;
        logic               block_end;
    } t_result;

    // What the current byte does to the block state.
    typedef struct packed {
        logic scale_low;    // byte is the low half of the scale
        logic scale_final;  // byte is the high half, block ends here
    } t_step;

endpackage

// ===== rtl/tbu_decode.sv =====
// ----------------------------------------------------------------------------
// tbu_decode
// Combinational decode of one superblock byte: codes, positions and scale.
// ----------------------------------------------------------------------------
module tbu_decode (
    input  logic                          i_format_mode,
    input  logic [tbu_pkg::PosWidth-1:0]  i_byte_pos,
    input  logic [7:0]                    i_byte,
    input  logic [7:0]                    i_scale_low,
    output tbu_pkg::t_result              o_result,
    output tbu_pkg::t_step                o_step
);

    localparam logic [7:0] Pow3 [0:4] = '{8'd1, 8'd3, 8'd9, 8'd27, 8'd81};

    // Widen a half-precision pattern to single precision.
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic        sgn;
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  msb;
        logic [10:0] shifted;
        logic [31:0] res;
        sgn = h[15];
        ex  = h[14:10];
        man = h[9:0];
        msb = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) begin
                msb = 4'(i);
            end
        end
        shifted = {1'b0, man} << (4'd10 - msb);
        if (ex == 5'd0) begin
            if (man == 10'd0) begin
                res = {sgn, 31'd0};
            end else begin
                // Subnormal: the leading one becomes the hidden bit.
                res = {sgn, 8'd103 + {4'd0, msb}, shifted[9:0], 13'd0};
            end
        end else if (ex == 5'h1f) begin
            res = {sgn, 8'hff, man, 13'd0};
        end else begin
            res = {sgn, {3'd0, ex} + 8'd112, man, 13'd0};
        end
        return res;
    endfunction

    // One trit: ((byte * 3^n) mod 256) * 3 >> 8, minus one.
    function automatic logic signed [1:0] trit_of(input logic [7:0] b,
                                                  input logic [7:0] pw);
        logic [15:0] prod;
        logic [9:0]  tri3;
        prod = b * pw;
        tri3 = prod[7:0] * 2'd3;
        return $signed(tri3[9:8] - 2'd1);
    endfunction

    logic [tbu_pkg::PosWidth-1:0] payload;
    logic signed [1:0]            trits [0:4];
    logic [7:0]                   pos8;

    always_comb begin
        payload = (i_format_mode == tbu_pkg::FMT_TQ1) ? tbu_pkg::Tq1Payload
                                                      : tbu_pkg::Tq2Payload;
        pos8    = {1'b0, i_byte_pos};
        for (int n = 0; n < 5; n++) begin
            trits[n] = trit_of(i_byte, Pow3[n]);
        end
    end

    // Classify the byte and build the result.
    always_comb begin
        o_result = '0;
        o_step   = '0;
        if (i_byte_pos >= payload + 7'd1) begin
            o_step.scale_final   = 1'b1;
            o_result.scale_valid = 1'b1;
            o_result.block_end   = 1'b1;
            o_result.scale_bits  = half_to_single({i_byte, i_scale_low});
        end else if (i_byte_pos == payload) begin
            o_step.scale_low = 1'b1;
        end else if (i_format_mode == tbu_pkg::FMT_TQ2) begin
            // Each 32-byte run covers one 128-code half.
            o_result.base_position   = {i_byte_pos[5], 2'b00, i_byte_pos[4:0]};
            o_result.position_stride = 6'd32;
            o_result.code_count      = 3'd4;
            o_result.code0 = $signed({1'b0, i_byte[1:0]} - 3'd1);
            o_result.code1 = $signed({1'b0, i_byte[3:2]} - 3'd1);
            o_result.code2 = $signed({1'b0, i_byte[5:4]} - 3'd1);
            o_result.code3 = $signed({1'b0, i_byte[7:6]} - 3'd1);
        end else begin
            o_result.code0 = 3'(trits[0]);
            o_result.code1 = 3'(trits[1]);
            o_result.code2 = 3'(trits[2]);
            o_result.code3 = 3'(trits[3]);
            if (pos8 < 8'(tbu_pkg::Tq1QsFull)) begin
                o_result.base_position   = pos8;
                o_result.position_stride = 6'd32;
                o_result.code_count      = 3'd5;
                o_result.code4           = trits[4];
            end else if (pos8 < 8'(tbu_pkg::Tq1Qs)) begin
                o_result.base_position   = pos8 + 8'(4 * tbu_pkg::Tq1QsFull);
                o_result.position_stride = 6'd16;
                o_result.code_count      = 3'd5;
                o_result.code4           = trits[4];
            end else begin
                o_result.base_position   = pos8 + 8'(4 * tbu_pkg::Tq1Qs);
                o_result.position_stride = 6'd4;
                o_result.code_count      = 3'd4;
            end
        end
    end

endmodule

// ===== rtl/ternary_block_unpacker.sv =====
// ----------------------------------------------------------------------------
// ternary_block_unpacker
// Unpacks ternary weight superblocks one byte per cycle when not stalled
// into signed codes with block positions and widens its half-precision scale.
// ----------------------------------------------------------------------------
//  Channel   Direction  Request content
//  s_axis    in         one raw superblock byte
//  m_axis    out        decoded codes and positions, scale on the last byte
//  APB       in/out     format_mode register at address 0
//
//  Each byte is decoded combinationally and its result is registered; one byte
//  per cycle is sustained unless stalled, set by the single decode stage.
//  A two-entry output stage (output register plus skid register) keeps
//  s_axis_tready high while one result waits; it drops only when both hold.
//  Reset clears the byte counter, the stored scale byte and format_mode.
// ----------------------------------------------------------------------------
module ternary_block_unpacker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] base_position, [13:8] position_stride, [16:14] code_count,
    // [19:17] code0, [22:20] code1, [25:23] code2, [28:26] code3,
    // [30:29] code4, [62:31] scale_bits, [63] zero
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tuser,   // [0] scale_valid
    output logic        m_axis_tlast,   // block_end
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                         r_format_mode;
    logic [tbu_pkg::PosWidth-1:0] r_byte_pos;
    logic [tbu_pkg::PosWidth-1:0] n_byte_pos;
    logic [7:0]                   r_scale_low;
    logic [7:0]                   n_scale_low;

    tbu_pkg::t_result r_out;
    tbu_pkg::t_result n_out;
    tbu_pkg::t_result r_skid;
    tbu_pkg::t_result n_skid;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_skid_valid;
    logic             n_skid_valid;

    tbu_pkg::t_result dec_result;
    tbu_pkg::t_step   dec_step;
    logic             accept;
    logic             cfg_write;

    // Configuration register access.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready & (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {31'd0, r_format_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format_mode <= tbu_pkg::FMT_TQ2;
        end else if (cfg_write) begin
            r_format_mode <= pwdata[0];
        end
    end

    // Byte decode.
    tbu_decode u_decode (
        .i_format_mode (r_format_mode),
        .i_byte_pos    (r_byte_pos),
        .i_byte        (s_axis_tdata),
        .i_scale_low   (r_scale_low),
        .o_result      (dec_result),
        .o_step        (dec_step)
    );

    assign s_axis_tready = ~r_skid_valid;
    assign accept        = s_axis_tvalid & s_axis_tready;

    // Block position and stored low scale byte.
    always_comb begin
        n_byte_pos  = r_byte_pos;
        n_scale_low = r_scale_low;
        if (accept) begin
            if (dec_step.scale_final) begin
                n_byte_pos = '0;
            end else begin
                n_byte_pos = r_byte_pos + 7'd1;
            end
            if (dec_step.scale_low) begin
                n_scale_low = s_axis_tdata;
            end
        end
    end

    // Output register with skid stage.
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (m_axis_tready || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = dec_result;
                n_out_valid = accept;
            end
        end else if (accept) begin
            n_skid       = dec_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos   <= '0;
            r_scale_low  <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_byte_pos   <= n_byte_pos;
            r_scale_low  <= n_scale_low;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    // Output packing.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.scale_bits, r_out.code4, r_out.code3,
                            r_out.code2, r_out.code1, r_out.code0,
                            r_out.code_count, r_out.position_stride,
                            r_out.base_position};
    assign m_axis_tuser  = r_out.scale_valid;
    assign m_axis_tlast  = r_out.block_end;

endmodule
